### src/vtp_pkg.sv
package vtp_pkg;

    localparam int BYTE_W  = 8;
    localparam int ARG_W   = 21;
    localparam int POS_W   = 8;
    localparam int COLOR_W = 26;
    localparam int PARAM_W = 16;
    localparam int SIZE_W  = 9;
    localparam int ACT_W   = 5;

    // actions
    localparam logic [ACT_W-1:0] ACT_PUT  = 5'd0;
    localparam logic [ACT_W-1:0] ACT_CR   = 5'd1;
    localparam logic [ACT_W-1:0] ACT_LF   = 5'd2;
    localparam logic [ACT_W-1:0] ACT_BS   = 5'd3;
    localparam logic [ACT_W-1:0] ACT_TAB  = 5'd4;
    localparam logic [ACT_W-1:0] ACT_BELL = 5'd5;
    localparam logic [ACT_W-1:0] ACT_RI   = 5'd6;
    localparam logic [ACT_W-1:0] ACT_SAVE = 5'd7;
    localparam logic [ACT_W-1:0] ACT_REST = 5'd8;
    localparam logic [ACT_W-1:0] ACT_RIS  = 5'd9;
    localparam logic [ACT_W-1:0] ACT_CUU  = 5'd10;
    localparam logic [ACT_W-1:0] ACT_CUD  = 5'd11;
    localparam logic [ACT_W-1:0] ACT_CUF  = 5'd12;
    localparam logic [ACT_W-1:0] ACT_CUB  = 5'd13;
    localparam logic [ACT_W-1:0] ACT_CNL  = 5'd14;
    localparam logic [ACT_W-1:0] ACT_CPL  = 5'd15;
    localparam logic [ACT_W-1:0] ACT_CHA  = 5'd16;
    localparam logic [ACT_W-1:0] ACT_CUP  = 5'd17;
    localparam logic [ACT_W-1:0] ACT_VPA  = 5'd18;
    localparam logic [ACT_W-1:0] ACT_ED   = 5'd19;
    localparam logic [ACT_W-1:0] ACT_EL   = 5'd20;
    localparam logic [ACT_W-1:0] ACT_SU   = 5'd21;
    localparam logic [ACT_W-1:0] ACT_SD   = 5'd22;
    localparam logic [ACT_W-1:0] ACT_VIS  = 5'd23;
    localparam logic [ACT_W-1:0] ACT_IL   = 5'd24;
    localparam logic [ACT_W-1:0] ACT_DL   = 5'd25;
    localparam logic [ACT_W-1:0] ACT_DCH  = 5'd26;
    localparam logic [ACT_W-1:0] ACT_ICH  = 5'd27;
    localparam logic [ACT_W-1:0] ACT_ECH  = 5'd28;

    // control bytes
    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_RBR  = 8'h5D;

    // escape finals
    localparam logic [7:0] ESC_DCS = 8'h50;
    localparam logic [7:0] ESC_RI  = 8'h4D;
    localparam logic [7:0] ESC_IND = 8'h44;
    localparam logic [7:0] ESC_NEL = 8'h45;
    localparam logic [7:0] ESC_SC  = 8'h37;
    localparam logic [7:0] ESC_RC  = 8'h38;
    localparam logic [7:0] ESC_RIS = 8'h63;

    // CSI finals
    localparam logic [7:0] FIN_CUU = 8'h41;
    localparam logic [7:0] FIN_CUD = 8'h42;
    localparam logic [7:0] FIN_CUF = 8'h43;
    localparam logic [7:0] FIN_CUB = 8'h44;
    localparam logic [7:0] FIN_CNL = 8'h45;
    localparam logic [7:0] FIN_CPL = 8'h46;
    localparam logic [7:0] FIN_CHA = 8'h47;
    localparam logic [7:0] FIN_CUP = 8'h48;
    localparam logic [7:0] FIN_HVP = 8'h66;
    localparam logic [7:0] FIN_VPA = 8'h64;
    localparam logic [7:0] FIN_ED  = 8'h4A;
    localparam logic [7:0] FIN_EL  = 8'h4B;
    localparam logic [7:0] FIN_SU  = 8'h53;
    localparam logic [7:0] FIN_SD  = 8'h54;
    localparam logic [7:0] FIN_SGR = 8'h6D;
    localparam logic [7:0] FIN_SM  = 8'h68;
    localparam logic [7:0] FIN_RM  = 8'h6C;
    localparam logic [7:0] FIN_SC  = 8'h73;
    localparam logic [7:0] FIN_RC  = 8'h75;
    localparam logic [7:0] FIN_IL  = 8'h4C;
    localparam logic [7:0] FIN_DL  = 8'h4D;
    localparam logic [7:0] FIN_DCH = 8'h50;
    localparam logic [7:0] FIN_ICH = 8'h40;
    localparam logic [7:0] FIN_ECH = 8'h58;

    localparam logic [1:0] KIND_PAL = 2'd1;
    localparam logic [1:0] KIND_RGB = 2'd2;
    localparam logic [PARAM_W-1:0] MODE_CURSOR = 16'd25;

    function automatic logic [COLOR_W-1:0] pal_color(input logic [7:0] idx);
        pal_color = {KIND_PAL, 16'd0, idx};
    endfunction

    function automatic logic [COLOR_W-1:0] rgb_color(input logic [7:0] r, input logic [7:0] g,
                                                      input logic [7:0] b);
        rgb_color = {KIND_RGB, r, g, b};
    endfunction

    // 6x6x6 cube entry, c in 16..231
    function automatic logic [COLOR_W-1:0] cube_color(input logic [7:0] c);
        logic [7:0] k;
        logic [7:0] rem;
        logic [2:0] r;
        logic [2:0] g;
        logic [7:0] bl;
        k = c - 8'd16;
        r = 3'd0;
        g = 3'd0;
        for (int t = 1; t <= 5; t++)
        begin
            if (k >= 8'(36 * t)) r = 3'(t);
        end
        rem = k - 8'(r) * 8'd36;
        for (int t = 1; t <= 5; t++)
        begin
            if (rem >= 8'(6 * t)) g = 3'(t);
        end
        bl = rem - 8'(g) * 8'd6;
        cube_color = rgb_color(8'(r) * 8'd51, 8'(g) * 8'd51, bl * 8'd51);
    endfunction

    function automatic logic [COLOR_W-1:0] grey_color(input logic [7:0] c);
        logic [7:0] v;
        v = (c - 8'd232) * 8'd10 + 8'd8;
        grey_color = rgb_color(v, v, v);
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input logic [PARAM_W-1:0] p1,
                                                   input logic [SIZE_W-1:0] size);
        logic [PARAM_W-1:0] v;
        logic [SIZE_W-1:0]  s;
        logic [PARAM_W-1:0] lim;
        v = p1 - 16'd1;
        if (size == 9'd0) s = 9'd1;
        else if (size > 9'd256) s = 9'd256;
        else s = size;
        lim = PARAM_W'(s - 9'd1);
        clamp_pos = (v > lim) ? lim[POS_W-1:0] : v[POS_W-1:0];
    endfunction

endpackage

### src/vtp_if.sv
interface vtp_byte_if;
    import vtp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface vtp_cmd_if;
    import vtp_pkg::*;
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [ARG_W-1:0]   arg_value;
    logic [POS_W-1:0]   target_row;
    logic [POS_W-1:0]   target_col;
    logic [COLOR_W-1:0] fg_colour;
    logic [COLOR_W-1:0] bg_colour;
    logic               is_bold;
    logic               is_italic;
    logic               is_underline;
    logic               last_of_run;
    modport source (output valid, output action, output arg_value, output target_row,
                    output target_col, output fg_colour, output bg_colour, output is_bold,
                    output is_italic, output is_underline, output last_of_run, input ready);
    modport sink   (input valid, input action, input arg_value, input target_row,
                    input target_col, input fg_colour, input bg_colour, input is_bold,
                    input is_italic, input is_underline, input last_of_run, output ready);
endinterface

### src/vtp_param_ram.sv
module vtp_param_ram
    import vtp_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [PARAM_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [PARAM_W-1:0] rdata
);

    logic [PARAM_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end

endmodule

### src/vt_escape_sequence_parser_core.sv
// Terminal byte parser: one byte per cycle while not stalled; a plain byte's word is registered as it is taken.
// ESC E gives two words, CR then LF, the LF held back while the output is stalled.
// A CSI final byte stalls input while its parameters are fetched (all for SGR, at most two
// for other finals): the parameter RAM is read one entry per cycle through its read port.
// rst_n clears parser, UTF-8 and style registers at once and sets the size registers to 24 rows
// and 80 columns; the parameter RAM is not cleared, every entry used is written first or forwarded.
module vt_escape_sequence_parser_core
    import vtp_pkg::*;
#(
    parameter int MAX_PARAMS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    vtp_byte_if.sink    bytes_in,
    vtp_cmd_if.source   cmds_out
);

    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);

    typedef enum logic [2:0] {
        M_GROUND, M_ESC, M_CSI_ENTRY, M_CSI_PARAM, M_CSI_INTER, M_OSC, M_DCS
    } mode_t;

    typedef enum logic [1:0] {C_RUN, C_FETCH, C_EXEC, C_SECOND} ctl_t;

    typedef enum logic [2:0] {X_NONE, X_SEL, X_R, X_G, X_B, X_PAL} ext_t;

    mode_t mode_reg, mode_next;
    ctl_t  ctl_reg, ctl_next;
    ext_t  ext_reg, ext_next;

    logic [1:0]         left_reg, left_next;
    logic [ARG_W-1:0]   accum_reg, accum_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               priv_reg, priv_next;
    logic               empty_reg, empty_next;
    logic               ovf_reg, ovf_next;
    logic [PARAM_W-1:0] cur_reg, cur_next;
    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic [2:0]         fl_reg, fl_next;
    logic [7:0]         fin_reg, fin_next;
    logic [CW-1:0]      nrd_reg, nrd_next;
    logic [CW-1:0]      iss_reg, iss_next;
    logic               pv_reg, pv_next;
    logic [AW-1:0]      pidx_reg, pidx_next;
    logic               xbg_reg, xbg_next;
    logic [7:0]         r_reg, r_next;
    logic [7:0]         g_reg, g_next;
    logic [PARAM_W-1:0] v0_reg, v0_next;
    logic [PARAM_W-1:0] v1_reg, v1_next;
    logic [SIZE_W-1:0]  rows_reg, cols_reg;

    logic               ov_reg;
    logic [ACT_W-1:0]   oact_reg;
    logic [ARG_W-1:0]   oarg_reg;
    logic [POS_W-1:0]   orow_reg, ocol_reg;
    logic [COLOR_W-1:0] ofg_reg, obg_reg;
    logic [2:0]         ofl_reg;
    logic               olast_reg;

    logic               load;
    logic [ACT_W-1:0]   ld_act;
    logic [ARG_W-1:0]   ld_arg;
    logic [POS_W-1:0]   ld_row, ld_col;
    logic               ld_last;

    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr;
    logic [PARAM_W-1:0] mem_wdata, mem_rdata;

    logic               free, acc, start, gcont, do_norm;
    logic [7:0]         b;
    logic [19:0]        prod;
    logic [PARAM_W-1:0] val, nv, a0, a1, p0, p1;
    logic [CW:0]        kk, nn;

    vtp_param_ram #(.DEPTH(MAX_PARAMS), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (iss_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign free           = !ov_reg || cmds_out.ready;
    assign bytes_in.ready = (ctl_reg == C_RUN) && free;
    assign acc            = bytes_in.valid && bytes_in.ready;
    assign b              = bytes_in.in_byte;
    assign pready         = 1'b1;
    assign prdata         = {23'd0, paddr[2] ? cols_reg : rows_reg};

    assign cmds_out.valid        = ov_reg;
    assign cmds_out.action       = oact_reg;
    assign cmds_out.arg_value    = oarg_reg;
    assign cmds_out.target_row   = orow_reg;
    assign cmds_out.target_col   = ocol_reg;
    assign cmds_out.fg_colour    = ofg_reg;
    assign cmds_out.bg_colour    = obg_reg;
    assign cmds_out.is_bold      = ofl_reg[0];
    assign cmds_out.is_italic    = ofl_reg[1];
    assign cmds_out.is_underline = ofl_reg[2];
    assign cmds_out.last_of_run  = olast_reg;

    // parameter stream with the open parameter forwarded from cur_reg
    assign val = (CW'(pidx_reg) == cnt_reg - CW'(1)) ? cur_reg : mem_rdata;
    assign kk  = (CW+1)'(pidx_reg);
    assign nn  = (CW+1)'(cnt_reg);
    assign a0  = (cnt_reg > CW'(0)) ? v0_reg : '0;
    assign a1  = (cnt_reg > CW'(1)) ? v1_reg : '0;
    assign p0  = (a0 == '0) ? 16'd1 : a0;
    assign p1  = (a1 == '0) ? 16'd1 : a1;
    assign prod = {4'd0, cur_reg} * 20'd10 + 20'(b[3:0]);

    always_comb
    begin
        mode_next  = mode_reg;
        ctl_next   = ctl_reg;
        ext_next   = ext_reg;
        left_next  = left_reg;
        accum_next = accum_reg;
        cnt_next   = cnt_reg;
        priv_next  = priv_reg;
        empty_next = empty_reg;
        ovf_next   = ovf_reg;
        cur_next   = cur_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        fl_next    = fl_reg;
        fin_next   = fin_reg;
        nrd_next   = nrd_reg;
        iss_next   = iss_reg;
        pv_next    = 1'b0;
        pidx_next  = pidx_reg;
        xbg_next   = xbg_reg;
        r_next     = r_reg;
        g_next     = g_reg;
        v0_next    = v0_reg;
        v1_next    = v1_reg;
        load       = 1'b0;
        ld_act     = ACT_PUT;
        ld_arg     = '0;
        ld_row     = '0;
        ld_col     = '0;
        ld_last    = 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        start      = 1'b0;
        gcont      = 1'b1;
        do_norm    = 1'b0;
        nv         = val;

        unique case (ctl_reg)
            C_RUN:
            begin
                if (acc)
                begin
                    unique case (mode_reg)
                        M_ESC:
                        begin
                            mode_next = M_GROUND;
                            case (b)
                                CH_LBR:
                                begin
                                    mode_next  = M_CSI_ENTRY;
                                    cnt_next   = '0;
                                    priv_next  = 1'b0;
                                    empty_next = 1'b1;
                                    ovf_next   = 1'b0;
                                    cur_next   = '0;
                                end
                                CH_RBR:  mode_next = M_OSC;
                                ESC_DCS: mode_next = M_DCS;
                                ESC_RI:  begin load = 1'b1; ld_act = ACT_RI; end
                                ESC_IND: begin load = 1'b1; ld_act = ACT_LF; end
                                ESC_NEL:
                                begin
                                    load    = 1'b1;
                                    ld_act  = ACT_CR;
                                    ld_last = 1'b0;
                                    ctl_next = C_SECOND;
                                end
                                ESC_SC:  begin load = 1'b1; ld_act = ACT_SAVE; end
                                ESC_RC:  begin load = 1'b1; ld_act = ACT_REST; end
                                ESC_RIS:
                                begin
                                    fg_next = '0;
                                    bg_next = '0;
                                    fl_next = '0;
                                    load    = 1'b1;
                                    ld_act  = ACT_RIS;
                                end
                                default: ;
                            endcase
                        end
                        M_CSI_ENTRY, M_CSI_PARAM, M_CSI_INTER:
                        begin
                            if (mode_reg == M_CSI_ENTRY &&
                                (b == CH_QM || b == CH_GT || b == CH_EQ || b == CH_LT))
                            begin
                                mode_next  = M_CSI_PARAM;
                                priv_next  = 1'b1;
                                empty_next = 1'b0;
                            end
                            else if (mode_reg != M_CSI_INTER &&
                                     ((b >= 8'h30 && b <= 8'h39) || b == CH_SEMI))
                            begin
                                mode_next  = M_CSI_PARAM;
                                empty_next = 1'b0;
                                if (b == CH_SEMI)
                                begin
                                    if (cnt_reg == '0)
                                    begin
                                        // empty first parameter, the second is opened
                                        mem_we   = 1'b1;
                                        mem_waddr = '0;
                                        mem_wdata = '0;
                                        cnt_next = CW'(2);
                                        cur_next = '0;
                                    end
                                    else if (cnt_reg < CW'(MAX_PARAMS))
                                    begin
                                        mem_we    = 1'b1;
                                        mem_waddr = AW'(cnt_reg - CW'(1));
                                        mem_wdata = cur_reg;
                                        cnt_next  = cnt_reg + CW'(1);
                                        cur_next  = '0;
                                    end
                                    else
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                end
                                else if (cnt_reg == '0)
                                begin
                                    cnt_next = CW'(1);
                                    cur_next = 16'(b[3:0]);
                                end
                                else if (!ovf_reg)
                                begin
                                    cur_next = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
                                end
                            end
                            else if (b >= 8'h20 && b <= 8'h2F)
                            begin
                                mode_next = M_CSI_INTER;
                            end
                            else
                            begin
                                mode_next = M_GROUND;
                                if (b >= 8'h40 && b <= 8'h7E) start = 1'b1;
                            end
                        end
                        M_OSC, M_DCS:
                        begin
                            if (b == CH_ESC || b == CH_BEL) mode_next = M_GROUND;
                        end
                        default:
                        begin
                            mode_next = M_GROUND;
                            if (left_reg != 2'd0)
                            begin
                                if (b[7:6] == 2'b10)
                                begin
                                    accum_next = {accum_reg[14:0], b[5:0]};
                                    left_next  = left_reg - 2'd1;
                                    gcont      = 1'b0;
                                    if (left_reg == 2'd1)
                                    begin
                                        load   = 1'b1;
                                        ld_arg = accum_next;
                                    end
                                end
                                else
                                begin
                                    // bad continuation: drop and reparse this byte
                                    left_next  = 2'd0;
                                    accum_next = '0;
                                end
                            end
                            if (gcont)
                            begin
                                case (b)
                                    CH_ESC: mode_next = M_ESC;
                                    CH_CR:  begin load = 1'b1; ld_act = ACT_CR; end
                                    CH_LF:  begin load = 1'b1; ld_act = ACT_LF; end
                                    CH_BS:  begin load = 1'b1; ld_act = ACT_BS; end
                                    CH_TAB: begin load = 1'b1; ld_act = ACT_TAB; end
                                    CH_BEL: begin load = 1'b1; ld_act = ACT_BELL; end
                                    CH_DEL: ;
                                    default:
                                    begin
                                        if (b >= 8'h20 && b < 8'h80)
                                        begin
                                            load   = 1'b1;
                                            ld_arg = 21'(b);
                                        end
                                        else if (b[7:5] == 3'b110)
                                        begin
                                            accum_next = 21'(b[4:0]);
                                            left_next  = 2'd1;
                                        end
                                        else if (b[7:4] == 4'b1110)
                                        begin
                                            accum_next = 21'(b[3:0]);
                                            left_next  = 2'd2;
                                        end
                                        else if (b[7:3] == 5'b11110)
                                        begin
                                            accum_next = 21'(b[2:0]);
                                            left_next  = 2'd3;
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase

                    if (start)
                    begin
                        fin_next = b;
                        iss_next = '0;
                        ext_next = X_NONE;
                        v0_next  = '0;
                        v1_next  = '0;
                        if (b == FIN_SGR)
                            nrd_next = cnt_reg;
                        else
                            nrd_next = (cnt_reg > CW'(2)) ? CW'(2) : cnt_reg;
                        if (nrd_next == '0) ctl_next = C_EXEC;
                        else ctl_next = C_FETCH;
                    end
                end
            end

            C_FETCH:
            begin
                if (iss_reg < nrd_reg)
                begin
                    mem_re    = 1'b1;
                    pv_next   = 1'b1;
                    pidx_next = iss_reg[AW-1:0];
                    iss_next  = iss_reg + CW'(1);
                end
                if (pv_reg)
                begin
                    if (fin_reg != FIN_SGR)
                    begin
                        if (pidx_reg == '0) v0_next = val;
                        else v1_next = val;
                    end
                    else
                    begin
                        case (ext_reg)
                            X_SEL:
                            begin
                                ext_next = X_NONE;
                                if (val == 16'd2 && kk + (CW+1)'(3) < nn) ext_next = X_R;
                                else if (val == 16'd5 && kk + (CW+1)'(1) < nn) ext_next = X_PAL;
                                else do_norm = 1'b1;
                            end
                            X_R: begin r_next = val[7:0]; ext_next = X_G; end
                            X_G: begin g_next = val[7:0]; ext_next = X_B; end
                            X_B:
                            begin
                                ext_next = X_NONE;
                                if (xbg_reg) bg_next = rgb_color(r_reg, g_reg, val[7:0]);
                                else fg_next = rgb_color(r_reg, g_reg, val[7:0]);
                            end
                            X_PAL:
                            begin
                                ext_next = X_NONE;
                                if (val <= 16'd255)
                                begin
                                    if (val <= 16'd15) r_next = 8'd0;
                                    if (xbg_reg)
                                        bg_next = (val <= 16'd15) ? pal_color(val[7:0]) :
                                                  (val <= 16'd231) ? cube_color(val[7:0]) :
                                                  grey_color(val[7:0]);
                                    else
                                        fg_next = (val <= 16'd15) ? pal_color(val[7:0]) :
                                                  (val <= 16'd231) ? cube_color(val[7:0]) :
                                                  grey_color(val[7:0]);
                                end
                            end
                            default: do_norm = 1'b1;
                        endcase
                        if (do_norm)
                        begin
                            nv = val;
                            if (nv == 16'd0)
                            begin
                                fg_next = '0;
                                bg_next = '0;
                                fl_next = '0;
                            end
                            else if (nv == 16'd1) fl_next[0] = 1'b1;
                            else if (nv == 16'd2 || nv == 16'd22) fl_next[0] = 1'b0;
                            else if (nv == 16'd3) fl_next[1] = 1'b1;
                            else if (nv == 16'd4) fl_next[2] = 1'b1;
                            else if (nv == 16'd23) fl_next[1] = 1'b0;
                            else if (nv == 16'd24) fl_next[2] = 1'b0;
                            else if (nv >= 16'd30 && nv <= 16'd37)
                                fg_next = pal_color(nv[7:0] - 8'd30);
                            else if (nv == 16'd39) fg_next = '0;
                            else if (nv >= 16'd40 && nv <= 16'd47)
                                bg_next = pal_color(nv[7:0] - 8'd40);
                            else if (nv == 16'd49) bg_next = '0;
                            else if (nv >= 16'd90 && nv <= 16'd97)
                                fg_next = pal_color(nv[7:0] - 8'd82);
                            else if (nv >= 16'd100 && nv <= 16'd107)
                                bg_next = pal_color(nv[7:0] - 8'd92);
                            else if ((nv == 16'd38 || nv == 16'd48) &&
                                     kk + (CW+1)'(1) < nn)
                            begin
                                ext_next = X_SEL;
                                xbg_next = (nv == 16'd48);
                            end
                        end
                    end
                    if (CW'(pidx_reg) == nrd_reg - CW'(1)) ctl_next = C_EXEC;
                end
            end

            C_EXEC:
            begin
                if (fin_reg == FIN_SGR)
                begin
                    if (cnt_reg == '0)
                    begin
                        fg_next = '0;
                        bg_next = '0;
                        fl_next = '0;
                    end
                    ctl_next = C_RUN;
                end
                else if (free)
                begin
                    ctl_next = C_RUN;
                    load     = 1'b1;
                    ld_arg   = 21'(p0);
                    case (fin_reg)
                        FIN_CUU: ld_act = ACT_CUU;
                        FIN_CUD: ld_act = ACT_CUD;
                        FIN_CUF: ld_act = ACT_CUF;
                        FIN_CUB: ld_act = ACT_CUB;
                        FIN_CNL: ld_act = ACT_CNL;
                        FIN_CPL: ld_act = ACT_CPL;
                        FIN_SU:  ld_act = ACT_SU;
                        FIN_SD:  ld_act = ACT_SD;
                        FIN_IL:  ld_act = ACT_IL;
                        FIN_DL:  ld_act = ACT_DL;
                        FIN_DCH: ld_act = ACT_DCH;
                        FIN_ICH: ld_act = ACT_ICH;
                        FIN_ECH: ld_act = ACT_ECH;
                        FIN_CHA:
                        begin
                            ld_act = ACT_CHA;
                            ld_arg = '0;
                            ld_col = clamp_pos(p0, cols_reg);
                        end
                        FIN_CUP, FIN_HVP:
                        begin
                            ld_act = ACT_CUP;
                            ld_arg = '0;
                            ld_row = clamp_pos(p0, rows_reg);
                            ld_col = clamp_pos(p1, cols_reg);
                        end
                        FIN_VPA:
                        begin
                            ld_act = ACT_VPA;
                            ld_arg = '0;
                            ld_row = clamp_pos(p0, rows_reg);
                        end
                        FIN_ED: begin ld_act = ACT_ED; ld_arg = 21'(a0); end
                        FIN_EL: begin ld_act = ACT_EL; ld_arg = 21'(a0); end
                        FIN_SM, FIN_RM:
                        begin
                            ld_act = ACT_VIS;
                            ld_arg = (fin_reg == FIN_SM) ? 21'd1 : 21'd0;
                            load   = priv_reg && (a0 == MODE_CURSOR);
                        end
                        FIN_SC: begin ld_act = ACT_SAVE; ld_arg = '0; end
                        FIN_RC:
                        begin
                            ld_act = ACT_REST;
                            ld_arg = '0;
                            load   = !priv_reg && empty_reg;
                        end
                        default: load = 1'b0;
                    endcase
                end
            end

            default:
            begin
                // second word of ESC E
                if (free)
                begin
                    load     = 1'b1;
                    ld_act   = ACT_LF;
                    ctl_next = C_RUN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_GROUND;
            ctl_reg   <= C_RUN;
            ext_reg   <= X_NONE;
            left_reg  <= '0;
            accum_reg <= '0;
            cnt_reg   <= '0;
            priv_reg  <= 1'b0;
            empty_reg <= 1'b1;
            ovf_reg   <= 1'b0;
            cur_reg   <= '0;
            fg_reg    <= '0;
            bg_reg    <= '0;
            fl_reg    <= '0;
            fin_reg   <= '0;
            nrd_reg   <= '0;
            iss_reg   <= '0;
            pv_reg    <= 1'b0;
            pidx_reg  <= '0;
            xbg_reg   <= 1'b0;
            r_reg     <= '0;
            g_reg     <= '0;
            v0_reg    <= '0;
            v1_reg    <= '0;
            rows_reg  <= 9'd24;
            cols_reg  <= 9'd80;
            ov_reg    <= 1'b0;
            oact_reg  <= '0;
            oarg_reg  <= '0;
            orow_reg  <= '0;
            ocol_reg  <= '0;
            ofg_reg   <= '0;
            obg_reg   <= '0;
            ofl_reg   <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            ctl_reg   <= ctl_next;
            ext_reg   <= ext_next;
            left_reg  <= left_next;
            accum_reg <= accum_next;
            cnt_reg   <= cnt_next;
            priv_reg  <= priv_next;
            empty_reg <= empty_next;
            ovf_reg   <= ovf_next;
            cur_reg   <= cur_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            fl_reg    <= fl_next;
            fin_reg   <= fin_next;
            nrd_reg   <= nrd_next;
            iss_reg   <= iss_next;
            pv_reg    <= pv_next;
            pidx_reg  <= pidx_next;
            xbg_reg   <= xbg_next;
            r_reg     <= r_next;
            g_reg     <= g_next;
            v0_reg    <= v0_next;
            v1_reg    <= v1_next;
            if (psel && penable && pwrite)
            begin
                if (paddr[2]) cols_reg <= pwdata[SIZE_W-1:0];
                else rows_reg <= pwdata[SIZE_W-1:0];
            end
            if (load)
            begin
                ov_reg    <= 1'b1;
                oact_reg  <= ld_act;
                oarg_reg  <= ld_arg;
                orow_reg  <= ld_row;
                ocol_reg  <= ld_col;
                ofg_reg   <= fg_next;
                obg_reg   <= bg_next;
                ofl_reg   <= fl_next;
                olast_reg <= ld_last;
            end
            else if (cmds_out.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

endmodule

### tb/vtp_tb_if.sv
`timescale 1ns / 100ps
// Channel interfaces come from the RTL (src/vtp_if.sv); this file holds the
// configuration port bundle used between the stimulus and the block.
interface vtp_apb_if;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
endinterface

### tb/vtp_cmd_checker.sv
`timescale 1ns / 100ps
module vtp_cmd_checker
    import vtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [8:0]  rows_cfg,
    input  logic [8:0]  cols_cfg,
    vtp_byte_if         bytes_in,
    vtp_cmd_if          cmds_out,
    output int          fail_count,
    output int          pending_cmds,
    output int          cmds_seen
);
    typedef enum logic [2:0] {
        PM_GROUND, PM_ESC, PM_CSI_ENTRY, PM_CSI_PARAM, PM_CSI_INTER, PM_OSC, PM_DCS
    } pmode_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [ARG_W-1:0]   arg;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic               bold;
        logic               italic;
        logic               uline;
        logic               last;
    } cmd_t;

    localparam int NPAR = 16;

    cmd_t expected_cmds[$];
    cmd_t step_cmds[$];

    pmode_t      pmode;
    logic [1:0]  u_left;
    logic [20:0] u_acc;
    int unsigned pvals[NPAR];
    int unsigned pcount;
    logic        priv, txt_empty, povf;
    logic [COLOR_W-1:0] fg, bg;
    logic [2:0]  flags;

    assign pending_cmds = expected_cmds.size();

    function automatic void push_cmd(logic [ACT_W-1:0] a, int unsigned arg,
                                     int unsigned r, int unsigned c);
        cmd_t e;
        if (step_cmds.size() >= 2) return;
        e.action = a;
        e.arg = arg[20:0];
        e.row = r[7:0];
        e.col = c[7:0];
        e.fg = fg;
        e.bg = bg;
        e.bold = flags[0];
        e.italic = flags[1];
        e.uline = flags[2];
        e.last = 1'b0;
        step_cmds.push_back(e);
    endfunction

    function automatic int unsigned pget(int unsigned idx, int unsigned def);
        if (idx < pcount && idx < NPAR && pvals[idx] > 0) return pvals[idx];
        return def;
    endfunction

    function automatic int unsigned clampp(int unsigned p1, int unsigned size);
        int unsigned v;
        v = p1 - 1;
        if (size == 0) size = 1;
        if (size > 256) size = 256;
        return (v > size - 1) ? size - 1 : v;
    endfunction

    function automatic logic [COLOR_W-1:0] mk_rgb(int unsigned r, int unsigned g,
                                                  int unsigned b);
        return {KIND_RGB, r[7:0], g[7:0], b[7:0]};
    endfunction

    function automatic int unsigned ext_color(int unsigned i, ref logic [COLOR_W-1:0] dst);
        int unsigned c, k, v;
        if (i + 1 >= pcount) return 0;
        if (pvals[i+1] == 2 && i + 4 < pcount) begin
            dst = mk_rgb(pvals[i+2], pvals[i+3], pvals[i+4]);
            return 4;
        end
        if (pvals[i+1] == 5 && i + 2 < pcount) begin
            c = pvals[i+2];
            if (c <= 15) dst = {KIND_PAL, 16'd0, c[7:0]};
            else if (c <= 231)
            begin
                k = c - 16;
                dst = mk_rgb((k / 36) * 51, ((k / 6) % 6) * 51, (k % 6) * 51);
            end
            else if (c <= 255)
            begin
                v = (c - 232) * 10 + 8;
                dst = mk_rgb(v, v, v);
            end
            return 2;
        end
        return 0;
    endfunction

    function automatic void apply_sgr();
        int unsigned i, c;
        if (pcount == 0)
        begin
            fg = '0; bg = '0; flags = '0;
            return;
        end
        for (i = 0; i < pcount && i < NPAR; i++)
        begin
            c = pvals[i];
            if (c == 0) begin fg = '0; bg = '0; flags = '0; end
            else if (c == 1) flags[0] = 1'b1;
            else if (c == 2 || c == 22) flags[0] = 1'b0;
            else if (c == 3) flags[1] = 1'b1;
            else if (c == 4) flags[2] = 1'b1;
            else if (c == 23) flags[1] = 1'b0;
            else if (c == 24) flags[2] = 1'b0;
            else if (c >= 30 && c <= 37) fg = {KIND_PAL, 16'd0, 8'(c - 30)};
            else if (c == 39) fg = '0;
            else if (c >= 40 && c <= 47) bg = {KIND_PAL, 16'd0, 8'(c - 40)};
            else if (c == 49) bg = '0;
            else if (c >= 90 && c <= 97) fg = {KIND_PAL, 16'd0, 8'(c - 82)};
            else if (c >= 100 && c <= 107) bg = {KIND_PAL, 16'd0, 8'(c - 92)};
            else if (c == 38) i += ext_color(i, fg);
            else if (c == 48) i += ext_color(i, bg);
        end
    endfunction

    function automatic void run_final(logic [7:0] f);
        case (f)
            FIN_CUU: push_cmd(ACT_CUU, pget(0, 1), 0, 0);
            FIN_CUD: push_cmd(ACT_CUD, pget(0, 1), 0, 0);
            FIN_CUF: push_cmd(ACT_CUF, pget(0, 1), 0, 0);
            FIN_CUB: push_cmd(ACT_CUB, pget(0, 1), 0, 0);
            FIN_CNL: push_cmd(ACT_CNL, pget(0, 1), 0, 0);
            FIN_CPL: push_cmd(ACT_CPL, pget(0, 1), 0, 0);
            FIN_CHA: push_cmd(ACT_CHA, 0, 0, clampp(pget(0, 1), cols_cfg));
            FIN_CUP, FIN_HVP:
                push_cmd(ACT_CUP, 0, clampp(pget(0, 1), rows_cfg),
                         clampp(pget(1, 1), cols_cfg));
            FIN_VPA: push_cmd(ACT_VPA, 0, clampp(pget(0, 1), rows_cfg), 0);
            FIN_ED:  push_cmd(ACT_ED, pget(0, 0), 0, 0);
            FIN_EL:  push_cmd(ACT_EL, pget(0, 0), 0, 0);
            FIN_SU:  push_cmd(ACT_SU, pget(0, 1), 0, 0);
            FIN_SD:  push_cmd(ACT_SD, pget(0, 1), 0, 0);
            FIN_SGR: apply_sgr();
            FIN_SM:  if (priv && pget(0, 0) == MODE_CURSOR) push_cmd(ACT_VIS, 1, 0, 0);
            FIN_RM:  if (priv && pget(0, 0) == MODE_CURSOR) push_cmd(ACT_VIS, 0, 0, 0);
            FIN_SC:  push_cmd(ACT_SAVE, 0, 0, 0);
            FIN_RC:  if (!priv && txt_empty) push_cmd(ACT_REST, 0, 0, 0);
            FIN_IL:  push_cmd(ACT_IL, pget(0, 1), 0, 0);
            FIN_DL:  push_cmd(ACT_DL, pget(0, 1), 0, 0);
            FIN_DCH: push_cmd(ACT_DCH, pget(0, 1), 0, 0);
            FIN_ICH: push_cmd(ACT_ICH, pget(0, 1), 0, 0);
            FIN_ECH: push_cmd(ACT_ECH, pget(0, 1), 0, 0);
            default: ;
        endcase
    endfunction

    function automatic void open_param();
        if (pcount < NPAR)
        begin
            pvals[pcount] = 0;
            pcount++;
        end
        else povf = 1'b1;
    endfunction

    function automatic void csi_char(logic [7:0] b);
        int unsigned v;
        if ((b >= "0" && b <= "9") || b == CH_SEMI)
        begin
            txt_empty = 1'b0;
            if (pcount == 0 && !povf) open_param();
            if (b == CH_SEMI) open_param();
            else if (!povf && pcount > 0 && pcount <= NPAR)
            begin
                v = pvals[pcount-1] * 10 + (b - "0");
                pvals[pcount-1] = (v > 65535) ? 65535 : v;
            end
            return;
        end
        if (b >= 8'h20 && b <= 8'h2F)
        begin
            pmode = PM_CSI_INTER;
            return;
        end
        pmode = PM_GROUND;
        if (b >= 8'h40 && b <= 8'h7E) run_final(b);
    endfunction

    function automatic void ground_char(logic [7:0] b);
        if (u_left > 0)
        begin
            if (b[7:6] == 2'b10)
            begin
                u_acc = {u_acc[14:0], b[5:0]};
                u_left--;
                if (u_left == 0) push_cmd(ACT_PUT, u_acc, 0, 0);
                return;
            end
            u_left = 0;
            u_acc = '0;
        end
        case (b)
            CH_ESC: begin pmode = PM_ESC; return; end
            CH_CR:  begin push_cmd(ACT_CR, 0, 0, 0); return; end
            CH_LF:  begin push_cmd(ACT_LF, 0, 0, 0); return; end
            CH_BS:  begin push_cmd(ACT_BS, 0, 0, 0); return; end
            CH_TAB: begin push_cmd(ACT_TAB, 0, 0, 0); return; end
            CH_BEL: begin push_cmd(ACT_BELL, 0, 0, 0); return; end
            CH_DEL: return;
            default: ;
        endcase
        if (b < 8'h20) return;
        if (b < 8'h80) push_cmd(ACT_PUT, b, 0, 0);
        else if (b[7:5] == 3'b110) begin u_acc = b[4:0]; u_left = 1; end
        else if (b[7:4] == 4'b1110) begin u_acc = b[3:0]; u_left = 2; end
        else if (b[7:3] == 5'b11110) begin u_acc = b[2:0]; u_left = 3; end
    endfunction

    function automatic void escape_char(logic [7:0] b);
        pmode = PM_GROUND;
        case (b)
            CH_LBR:
            begin
                pmode = PM_CSI_ENTRY;
                pcount = 0; priv = 1'b0; txt_empty = 1'b1; povf = 1'b0;
            end
            CH_RBR:  pmode = PM_OSC;
            ESC_DCS: pmode = PM_DCS;
            ESC_RI:  push_cmd(ACT_RI, 0, 0, 0);
            ESC_IND: push_cmd(ACT_LF, 0, 0, 0);
            ESC_NEL:
            begin
                push_cmd(ACT_CR, 0, 0, 0);
                push_cmd(ACT_LF, 0, 0, 0);
            end
            ESC_SC:  push_cmd(ACT_SAVE, 0, 0, 0);
            ESC_RC:  push_cmd(ACT_REST, 0, 0, 0);
            ESC_RIS:
            begin
                fg = '0; bg = '0; flags = '0;
                push_cmd(ACT_RIS, 0, 0, 0);
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        step_cmds.delete();
        case (pmode)
            PM_ESC: escape_char(b);
            PM_CSI_ENTRY:
            begin
                pmode = PM_CSI_PARAM;
                if (b == CH_QM || b == CH_GT || b == CH_EQ || b == CH_LT)
                begin
                    priv = 1'b1;
                    txt_empty = 1'b0;
                end
                else csi_char(b);
            end
            PM_CSI_PARAM: csi_char(b);
            PM_CSI_INTER:
                if (!(b >= 8'h20 && b <= 8'h2F))
                begin
                    pmode = PM_GROUND;
                    if (b >= 8'h40 && b <= 8'h7E) run_final(b);
                end
            PM_OSC, PM_DCS: if (b == CH_ESC || b == CH_BEL) pmode = PM_GROUND;
            default: ground_char(b);
        endcase
        if (step_cmds.size() > 0) step_cmds[step_cmds.size()-1].last = 1'b1;
        foreach (step_cmds[k]) expected_cmds.push_back(step_cmds[k]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cmd_t got, exp_c;
        if (!rst_n)
        begin
            pmode = PM_GROUND; u_left = 0; u_acc = '0;
            pcount = 0; priv = 1'b0; txt_empty = 1'b1; povf = 1'b0;
            fg = '0; bg = '0; flags = '0;
            fail_count <= 0;
            cmds_seen <= 0;
            expected_cmds.delete();
        end
        else
        begin
            // outputs before inputs: a word can't come from a byte in the same edge
            if (cmds_out.valid && cmds_out.ready)
            begin
                got = {cmds_out.action, cmds_out.arg_value, cmds_out.target_row,
                       cmds_out.target_col, cmds_out.fg_colour, cmds_out.bg_colour,
                       cmds_out.is_bold, cmds_out.is_italic, cmds_out.is_underline,
                       cmds_out.last_of_run};
                cmds_seen <= cmds_seen + 1;
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_c = expected_cmds.pop_front();
                    if (got !== exp_c)
                    begin
                        $display("%0t: mismatch act %0d/%0d arg %h/%h row %0d/%0d col %0d/%0d",
                                 $time, exp_c.action, got.action, exp_c.arg, got.arg,
                                 exp_c.row, got.row, exp_c.col, got.col);
                        $display("    fg %h/%h bg %h/%h flags %b/%b last %b/%b",
                                 exp_c.fg, got.fg, exp_c.bg, got.bg,
                                 {exp_c.bold, exp_c.italic, exp_c.uline},
                                 {got.bold, got.italic, got.uline}, exp_c.last, got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (bytes_in.valid && bytes_in.ready) predict_byte(bytes_in.in_byte);
        end
    end
endmodule

### tb/tb_vt_escape_sequence_parser_core.sv
`timescale 1ns / 100ps
module tb_vt_escape_sequence_parser_core;
    import vtp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [8:0] rows_cfg = 9'd24;
    logic [8:0] cols_cfg = 9'd80;
    int fail_count, pending_cmds, cmds_seen;
    int cycles = 0;
    int bytes_sent = 0;
    bit calm_phase = 0;
    bit hold_sink = 0;
    bit random_done = 0;
    logic [7:0] seq_buf[$];

    vtp_byte_if bytes_ch();
    vtp_cmd_if  cmds_ch();
    vtp_apb_if  apb();

    initial
    begin
        apb.psel = 1'b0; apb.penable = 1'b0; apb.pwrite = 1'b0;
        apb.paddr = '0; apb.pwdata = '0;
        bytes_ch.valid = 1'b0; bytes_ch.in_byte = '0;
        cmds_ch.ready = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    vt_escape_sequence_parser_core dut (
        .clk(clk), .rst_n(rst_n),
        .psel(apb.psel), .penable(apb.penable), .pwrite(apb.pwrite),
        .paddr(apb.paddr), .pwdata(apb.pwdata), .prdata(apb.prdata), .pready(apb.pready),
        .bytes_in(bytes_ch), .cmds_out(cmds_ch)
    );

    vtp_cmd_checker chk (
        .clk(clk), .rst_n(rst_n), .rows_cfg(rows_cfg), .cols_cfg(cols_cfg),
        .bytes_in(bytes_ch), .cmds_out(cmds_ch), .fail_count(fail_count),
        .pending_cmds(pending_cmds), .cmds_seen(cmds_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycles, pending_cmds);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, none in the calm phase, long hold when asked
    always @(posedge clk)
    begin
        if (!rst_n) cmds_ch.ready <= 1'b0;
        else if (hold_sink) cmds_ch.ready <= 1'b0;
        else if (calm_phase) cmds_ch.ready <= 1'b1;
        else cmds_ch.ready <= ($urandom_range(99) >= 34);
    end

    initial
    begin
        wait (bytes_sent >= 400);
        @(posedge clk);
        hold_sink = 1'b1;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
    end

    task automatic cfg_write(input int idx, input logic [8:0] val);
        @(posedge clk);
        apb.psel <= 1'b1; apb.pwrite <= 1'b1; apb.penable <= 1'b0;
        apb.paddr <= 3'(idx * 4); apb.pwdata <= {23'd0, val};
        @(posedge clk);
        apb.penable <= 1'b1;
        @(posedge clk);
        apb.psel <= 1'b0; apb.penable <= 1'b0; apb.pwrite <= 1'b0;
        if (idx == 0) rows_cfg <= val;
        else cols_cfg <= val;
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (!calm_phase && $urandom_range(99) < 34)
        begin
            @(posedge clk);
            bytes_ch.valid <= 1'b0;
        end
        @(posedge clk);
        bytes_ch.valid <= 1'b1;
        bytes_ch.in_byte <= b;
        do @(posedge clk); while (!bytes_ch.ready);
        bytes_sent++;
        // deassert at this same edge; the next byte, if any, is driven at a later edge
        bytes_ch.valid <= 1'b0;
        #0;
    endtask

    task automatic flush_seq();
        while (seq_buf.size() > 0) send_byte(seq_buf.pop_front());
    endtask

    task automatic wait_idle();
        @(posedge clk);
        bytes_ch.valid <= 1'b0;
        while (pending_cmds != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic void add_num(int unsigned n);
        string s;
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++) seq_buf.push_back(s[i]);
    endfunction

    function automatic void add_csi(string body);
        seq_buf.push_back(CH_ESC);
        seq_buf.push_back(CH_LBR);
        for (int i = 0; i < body.len(); i++) seq_buf.push_back(body[i]);
    endfunction

    function automatic logic [7:0] pick_final();
        logic [7:0] fins[24];
        fins = '{FIN_CUU, FIN_CUD, FIN_CUF, FIN_CUB, FIN_CNL, FIN_CPL, FIN_CHA, FIN_CUP,
                 FIN_HVP, FIN_VPA, FIN_ED, FIN_EL, FIN_SU, FIN_SD, FIN_SGR, FIN_SM,
                 FIN_RM, FIN_SC, FIN_RC, FIN_IL, FIN_DL, FIN_DCH, FIN_ICH, FIN_ECH};
        return fins[$urandom_range(23)];
    endfunction

    function automatic int unsigned rand_param();
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom_range(65535, 60000);
            2: return 99999;
            3: return 25;
            4, 5: return $urandom_range(300);
            default: return $urandom_range(9);
        endcase
    endfunction

    function automatic void build_random_seq();
        int unsigned n, kind;
        logic [7:0] escs[10];
        escs = '{CH_LBR, CH_RBR, ESC_DCS, ESC_RI, ESC_IND, ESC_NEL, ESC_SC, ESC_RC,
                 ESC_RIS, 8'h5A};
        kind = $urandom_range(99);
        if (kind < 25)
        begin
            // text: ASCII, UTF-8, control and random bytes
            n = $urandom_range(4, 1);
            repeat (n)
            begin
                case ($urandom_range(5))
                    0: seq_buf.push_back(8'($urandom_range(8'h7E, 8'h20)));
                    1:
                    begin
                        seq_buf.push_back({3'b110, 5'($urandom)});
                        seq_buf.push_back({2'b10, 6'($urandom)});
                    end
                    2:
                    begin
                        seq_buf.push_back({4'b1110, 4'($urandom)});
                        seq_buf.push_back({2'b10, 6'($urandom)});
                        seq_buf.push_back({2'b10, 6'($urandom)});
                    end
                    3:
                    begin
                        seq_buf.push_back({5'b11110, 3'($urandom)});
                        repeat (3) seq_buf.push_back({2'b10, 6'($urandom)});
                    end
                    4: seq_buf.push_back(8'($urandom_range(8'h1F)));
                    default: seq_buf.push_back(8'($urandom));
                endcase
            end
        end
        else if (kind < 65)
        begin
            // CSI with random parameters
            seq_buf.push_back(CH_ESC);
            seq_buf.push_back(CH_LBR);
            if ($urandom_range(5) == 0) seq_buf.push_back(CH_QM);
            n = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(3);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0) seq_buf.push_back(CH_SEMI);
                if ($urandom_range(7) != 0) add_num(rand_param());
            end
            if ($urandom_range(15) == 0) seq_buf.push_back(8'($urandom_range(8'h2F, 8'h20)));
            if ($urandom_range(19) == 0) seq_buf.push_back(8'($urandom));
            else seq_buf.push_back(pick_final());
        end
        else if (kind < 80)
        begin
            // SGR with colors
            add_csi("");
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0) seq_buf.push_back(CH_SEMI);
                case ($urandom_range(4))
                    0:
                    begin
                        add_num($urandom_range(1) ? 38 : 48);
                        seq_buf.push_back(CH_SEMI);
                        seq_buf.push_back("5");
                        seq_buf.push_back(CH_SEMI);
                        add_num($urandom_range(300));
                    end
                    1:
                    begin
                        add_num($urandom_range(1) ? 38 : 48);
                        seq_buf.push_back(CH_SEMI);
                        seq_buf.push_back("2");
                        repeat ($urandom_range(3)) begin
                            seq_buf.push_back(CH_SEMI);
                            add_num($urandom_range(999));
                        end
                    end
                    default: add_num($urandom_range(108));
                endcase
            end
            seq_buf.push_back(FIN_SGR);
        end
        else if (kind < 92)
        begin
            seq_buf.push_back(CH_ESC);
            seq_buf.push_back(escs[$urandom_range(9)]);
            if (seq_buf[seq_buf.size()-1] == CH_RBR || seq_buf[seq_buf.size()-1] == ESC_DCS)
            begin
                repeat ($urandom_range(6)) seq_buf.push_back(8'($urandom_range(8'h7E, 8'h20)));
                seq_buf.push_back($urandom_range(1) ? CH_BEL : CH_ESC);
            end
        end
        else seq_buf.push_back(8'($urandom));
    endfunction

    initial
    begin
        logic [8:0] sizes[4][2];
        sizes = '{'{9'd1, 9'd256}, '{9'd256, 9'd1}, '{9'd0, 9'd300}, '{9'd511, 9'd0}};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        cfg_write(0, 9'd24);
        cfg_write(1, 9'd80);

        // directed
        seq_buf.push_back(8'h41);
        seq_buf.push_back(8'h00); seq_buf.push_back(CH_DEL);
        seq_buf.push_back(CH_CR); seq_buf.push_back(CH_LF); seq_buf.push_back(CH_BS);
        seq_buf.push_back(CH_TAB); seq_buf.push_back(CH_BEL);
        seq_buf.push_back(8'hF4); seq_buf.push_back(8'h8F); seq_buf.push_back(8'hBF);
        seq_buf.push_back(8'hBF);
        seq_buf.push_back(8'hE2); seq_buf.push_back(8'h41);      // bad continuation
        seq_buf.push_back(8'hFF);
        seq_buf.push_back(CH_ESC); seq_buf.push_back(ESC_NEL);
        add_csi("1;38;2;300;20;255;48;5;232;4;3m");
        seq_buf.push_back(8'h7E);
        add_csi("999;70000H");
        add_csi("?25l"); add_csi("?25h"); add_csi("u"); add_csi(";u");
        add_csi("1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18G");
        flush_seq();
        wait_idle();

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph < 4)
            begin
                cfg_write(0, sizes[ph][0]);
                cfg_write(1, sizes[ph][1]);
            end
            else
            begin
                cfg_write(0, 9'($urandom_range(256, 1)));
                cfg_write(1, 9'($urandom_range(256, 1)));
            end
            calm_phase = (ph == 2);
            while (bytes_sent < 250 + ph * 200)
            begin
                build_random_seq();
                flush_seq();
            end
            wait_idle();
        end
        random_done = 1'b1;
        wait_idle();
        $display("sent %0d bytes over 6 screen sizes, checked %0d command words",
                 bytes_sent, cmds_seen);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
